// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the deque top module, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define DQ_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define DQ_ASSERT(lbl, clk, rst, prop, msg)

`define DQ_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants of the bounded deque with insert and find.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   localparam int WORD_W       = 32;
   localparam int OP_W         = 3;
   localparam int IDX_W        = 6;
   localparam int ERR_W        = 3;
   localparam int CNT_OUT_W    = 7;
   localparam int DEF_CAPACITY = 64;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_READ       = 3'd5,
      OP_FIND       = 3'd6
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_EMPTY    = 3'd1,
      ERR_INDEX    = 3'd2,
      ERR_NOTFOUND = 3'd3,
      ERR_FULL     = 3'd4
   } err_type;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [WORD_W-1:0] value;
      logic [IDX_W-1:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [ERR_W-1:0]         error;
      logic [CNT_OUT_W-1:0]     count;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              match;
      logic              commit;
      logic [OP_W-1:0]   operation;
      logic [WORD_W-1:0] value;
      logic [IDX_W-1:0]  index;
   } ctl_type;

endpackage

`default_nettype wire

// File: sv/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One storage slot of the row: shifts, loads and flags a hit for its position.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell #(
   parameter int POS   = 0,
   parameter int CNT_W = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dq_pkg::ctl_type             ctl,
   input  wire logic [CNT_W-1:0]            count,
   input  wire logic [dq_pkg::WORD_W-1:0]   left_word,
   input  wire logic [dq_pkg::WORD_W-1:0]   right_word,
   output logic [dq_pkg::WORD_W-1:0]        word,
   output logic                             hit
);

   localparam int CMP_W = ((CNT_W > dq_pkg::IDX_W) ? CNT_W : dq_pkg::IDX_W) + 1;
   localparam logic [CMP_W-1:0] POS_C = CMP_W'(POS);

   logic [dq_pkg::WORD_W-1:0] word_ff, word_in;
   logic                      hit_ff, hit_in;
   logic [CMP_W-1:0]          cnt_x, idx_x, idx_nx, pos_nx;

   assign cnt_x  = CMP_W'(count);
   assign idx_x  = CMP_W'(ctl.index);
   assign idx_nx = idx_x + CMP_W'(1);
   assign pos_nx = POS_C + CMP_W'(1);

   always_comb begin
      word_in = word_ff;
      hit_in  = hit_ff;
      if (ctl.commit) begin
         case (ctl.operation)
            dq_pkg::OP_PUSH_BACK: begin
               if (POS_C == cnt_x) word_in = ctl.value;
            end
            dq_pkg::OP_PUSH_FRONT: begin
               if (POS_C == '0) word_in = ctl.value;
               else if (POS_C <= cnt_x) word_in = left_word;
            end
            dq_pkg::OP_POP_FRONT: begin
               if (pos_nx < cnt_x) word_in = right_word;
            end
            dq_pkg::OP_INSERT: begin
               if (POS_C == idx_nx) word_in = ctl.value;
               else if (POS_C > idx_nx && POS_C <= cnt_x) word_in = left_word;
            end
            default: ;
         endcase
      end
      if (ctl.match) begin
         case (ctl.operation)
            dq_pkg::OP_POP_BACK:  hit_in = (pos_nx == cnt_x);
            dq_pkg::OP_POP_FRONT: hit_in = (POS_C == '0) && (cnt_x != '0);
            dq_pkg::OP_READ:      hit_in = (POS_C == idx_x) && (POS_C < cnt_x);
            dq_pkg::OP_FIND:      hit_in = (word_ff == ctl.value) && (POS_C < cnt_x);
            default:              hit_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign word = word_ff;
   assign hit  = hit_ff;

endmodule

`default_nettype wire

// File: sv/dq_pick.sv
// ----------------------------------------------------------------------------
// dq_pick
// Reduces the row's hit flags: any hit, lowest hit position, selected word.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_pick #(
   parameter int N  = 64,
   parameter int PW = 6
) (
   input  wire logic [N-1:0]                       hits,
   input  wire logic [N-1:0][dq_pkg::WORD_W-1:0]   words,
   output logic                                    any_hit,
   output logic [PW-1:0]                           first_pos,
   output logic [dq_pkg::WORD_W-1:0]               sel_word
);

   always_comb begin
      any_hit   = |hits;
      first_pos = '0;
      sel_word  = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (hits[i]) first_pos = PW'(i);
      end
      for (int i = 0; i < N; i++) begin
         sel_word = sel_word | (words[i] & {dq_pkg::WORD_W{hits[i]}});
      end
   end

endmodule

`default_nettype wire

// File: sv/bounded_deque_with_insert_find.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_insert_find
// Ordered store of signed words in a row of shifting cells: push and pop at
// both ends, insert after a position, read at a position and find a word.
// ----------------------------------------------------------------------------
//  channel   ports                              direction
//  request   req_valid req_ready req_payload    in
//  response  rsp_valid rsp_ready rsp_payload    out
//
//  each request goes through accept, a match pass over the cell row,
//  then apply (result written, row shifted, count updated)
//  the apply cycle waits while the response register is still held
//  a new request is accepted while a response waits to be taken
//  synchronous reset clears the count and control, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bounded_deque_with_insert_find #(
   parameter int CAPACITY = dq_pkg::DEF_CAPACITY
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire dq_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output dq_pkg::rsp_type      rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PW    = $clog2(CAPACITY);
   localparam int CMP_W = ((CNT_W > dq_pkg::IDX_W) ? CNT_W : dq_pkg::IDX_W) + 1;
   localparam int W     = dq_pkg::WORD_W;

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY} state_type;

   state_type          state_ff, state_in;
   dq_pkg::req_type    req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   dq_pkg::rsp_type    rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   dq_pkg::ctl_type            ctl;
   logic [CAPACITY-1:0][W-1:0] words;
   logic [CAPACITY-1:0]        hits;
   logic                       any_hit;
   logic [PW-1:0]              first_pos;
   logic [W-1:0]               sel_word;

   logic             apply_go, commit_ok, full, empty, idx_bad;
   logic             in_apply, one_hit_ok;
   logic [W-1:0]     data_r;
   logic [dq_pkg::ERR_W-1:0] err_r;
   logic [CNT_W-1:0] count_r;

   assign in_apply   = (state_ff == S_APPLY);
   assign apply_go   = in_apply && (!rsp_valid_ff || rsp_ready);
   assign full       = count_ff >= CNT_W'(CAPACITY);
   assign empty      = count_ff == '0;
   assign idx_bad    = CMP_W'(req_ff.index) >= CMP_W'(count_ff);
   assign one_hit_ok = $onehot0(hits) || (req_ff.operation == dq_pkg::OP_FIND);

   always_comb begin
      data_r    = '0;
      err_r     = dq_pkg::ERR_NONE;
      count_r   = count_ff;
      commit_ok = 1'b0;
      case (req_ff.operation)
         dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               err_r = dq_pkg::ERR_FULL;
            end else begin
               commit_ok = 1'b1;
               count_r   = count_ff + CNT_W'(1);
            end
         end
         dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               err_r = dq_pkg::ERR_EMPTY;
            end else begin
               commit_ok = 1'b1;
               data_r    = sel_word;
               count_r   = count_ff - CNT_W'(1);
            end
         end
         dq_pkg::OP_INSERT: begin
            if (idx_bad) begin
               err_r = dq_pkg::ERR_INDEX;
            end else if (full) begin
               err_r = dq_pkg::ERR_FULL;
            end else begin
               commit_ok = 1'b1;
               count_r   = count_ff + CNT_W'(1);
            end
         end
         dq_pkg::OP_READ: begin
            if (idx_bad) begin
               err_r  = dq_pkg::ERR_INDEX;
               data_r = '1;
            end else begin
               data_r = sel_word;
            end
         end
         dq_pkg::OP_FIND: begin
            if (any_hit) begin
               data_r = W'(first_pos);
            end else begin
               err_r  = dq_pkg::ERR_NOTFOUND;
               data_r = '1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      ctl.match     = (state_ff == S_MATCH);
      ctl.commit    = apply_go && commit_ok;
      ctl.operation = req_ff.operation;
      ctl.value     = req_ff.value;
      ctl.index     = req_ff.index;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_go) begin
               rsp_in.data  = data_r;
               rsp_in.error = err_r;
               rsp_in.count = dq_pkg::CNT_OUT_W'(count_r);
               rsp_valid_in = 1'b1;
               count_in     = count_r;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [W-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = req_ff.value;
      end else begin : g_mid_l
         assign left_w = words[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = words[g+1];
      end
      dq_cell #(
         .POS   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .count      (count_ff),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (words[g]),
         .hit        (hits[g])
      );
   end

   dq_pick #(
      .N  (CAPACITY),
      .PW (PW)
   ) u_pick (
      .hits      (hits),
      .words     (words),
      .any_hit   (any_hit),
      .first_pos (first_pos),
      .sel_word  (sel_word)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `DQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `DQ_IMPLY(a_single_hit, clock, reset, in_apply, one_hit_ok, "several cells hit")
   `DQ_IMPLY(a_count_from_apply, clock, reset, !$stable(count_ff), $past(in_apply), "count moved")
   `DQ_IMPLY(a_rsp_from_apply, clock, reset, $rose(rsp_valid_ff), $past(in_apply), "stray response")

endmodule

`default_nettype wire

// File: test/bounded_deque_with_insert_find_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_insert_find_tb
// Self-checking bench for the bounded deque: requests are mirrored into a
// local copy of the word store, and each response is compared field by field
// with the oldest prediction, under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bounded_deque_with_insert_find_tb;

   localparam int CAPACITY = dq_pkg::DEF_CAPACITY;
   localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_ITEMS = 450;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   dq_pkg::req_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   dq_pkg::rsp_type rsp_payload;

   logic signed [dq_pkg::WORD_W-1:0] shadow_words [0:CAPACITY-1];
   int              shadow_count = 0;
   dq_pkg::rsp_type pending_responses [$];
   int              failures = 0;
   int              idle_cycles = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   logic            hold_request = 1'b0;
   int              hold_left = 0;

   bounded_deque_with_insert_find dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic dq_pkg::rsp_type predict_response(input dq_pkg::req_type r);
      dq_pkg::rsp_type res;
      int n;
      int idx;
      logic hit;
      res.data = '0;
      res.error = dq_pkg::ERR_NONE;
      n = shadow_count;
      idx = int'(r.index);
      case (r.operation)
         dq_pkg::OP_PUSH_BACK: begin
            if (n >= CAPACITY) res.error = dq_pkg::ERR_FULL;
            else begin
               shadow_words[n] = r.value;
               n++;
            end
         end
         dq_pkg::OP_POP_BACK: begin
            if (n == 0) res.error = dq_pkg::ERR_EMPTY;
            else begin
               n--;
               res.data = shadow_words[n];
            end
         end
         dq_pkg::OP_PUSH_FRONT: begin
            if (n >= CAPACITY) res.error = dq_pkg::ERR_FULL;
            else begin
               for (int i = n; i > 0; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[0] = r.value;
               n++;
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            if (n == 0) res.error = dq_pkg::ERR_EMPTY;
            else begin
               res.data = shadow_words[0];
               for (int i = 0; i + 1 < n; i++) shadow_words[i] = shadow_words[i+1];
               n--;
            end
         end
         dq_pkg::OP_INSERT: begin
            if (idx >= n) res.error = dq_pkg::ERR_INDEX;
            else if (n >= CAPACITY) res.error = dq_pkg::ERR_FULL;
            else begin
               for (int i = n; i > idx + 1; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[idx+1] = r.value;
               n++;
            end
         end
         dq_pkg::OP_READ: begin
            if (idx >= n) begin
               res.error = dq_pkg::ERR_INDEX;
               res.data = -1;
            end else begin
               res.data = shadow_words[idx];
            end
         end
         dq_pkg::OP_FIND: begin
            res.data = -1;
            res.error = dq_pkg::ERR_NOTFOUND;
            hit = 1'b0;
            for (int i = 0; i < n; i++) begin
               if (!hit && shadow_words[i] == r.value) begin
                  hit = 1'b1;
                  res.data = i;
                  res.error = dq_pkg::ERR_NONE;
               end
            end
         end
         default: ;
      endcase
      shadow_count = n;
      res.count = n[dq_pkg::CNT_OUT_W-1:0];
      return res;
   endfunction

   // response check, request capture and watchdog
   always @(posedge clock) begin
      dq_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               failures++;
               $display("%0t: expected no response actual %p", $time, rsp_payload);
            end else begin
               want = pending_responses[0];
               pending_responses.delete(0);
               if (rsp_payload.data !== want.data) begin
                  failures++;
                  $display("%0t: data expected %0d actual %0d", $time, want.data,
                           rsp_payload.data);
               end
               if (rsp_payload.error !== want.error) begin
                  failures++;
                  $display("%0t: error expected %0d actual %0d", $time, want.error,
                           rsp_payload.error);
               end
               if (rsp_payload.count !== want.count) begin
                  failures++;
                  $display("%0t: count expected %0d actual %0d", $time, want.count,
                           rsp_payload.count);
               end
            end
         end
         if (req_valid && req_ready)
            pending_responses.insert(pending_responses.size(),
                                     predict_response(req_payload));
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // response side: random stalls and the long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(input logic [dq_pkg::OP_W-1:0] op,
                               input logic signed [dq_pkg::WORD_W-1:0] value,
                               input logic [dq_pkg::IDX_W-1:0] index);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{operation: op, value: value, index: index};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_all_done();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_responses.size() != 0) @(negedge clock);
   endtask

   task automatic test_empty_store();
      send_request(dq_pkg::OP_POP_BACK, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_POP_FRONT, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_READ, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_READ, 32'sd0, 6'd63);
      send_request(dq_pkg::OP_FIND, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_INSERT, 32'sd5, 6'd0);
      send_request(OP_UNUSED, -32'sd1, 6'd63);
      wait_all_done();
   endtask

   task automatic test_ends_and_middle();
      send_request(dq_pkg::OP_PUSH_BACK, 32'sh7FFFFFFF, 6'd0);
      send_request(dq_pkg::OP_PUSH_FRONT, 32'sh80000000, 6'd63);
      send_request(dq_pkg::OP_PUSH_BACK, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_PUSH_FRONT, -32'sd1, 6'd0);
      send_request(dq_pkg::OP_INSERT, 32'sh55555555, 6'd0);
      send_request(dq_pkg::OP_INSERT, 32'shAAAAAAAA, 6'd4);
      send_request(dq_pkg::OP_INSERT, 32'sd1, 6'd6);
      send_request(dq_pkg::OP_INSERT, 32'sd1, 6'd63);
      send_request(dq_pkg::OP_PUSH_BACK, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_READ, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_READ, 32'sd0, 6'd5);
      send_request(dq_pkg::OP_READ, 32'sd0, 6'd63);
      send_request(dq_pkg::OP_FIND, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_FIND, 32'sh7FFFFFFF, 6'd0);
      send_request(dq_pkg::OP_FIND, 32'sh12345678, 6'd0);
      send_request(OP_UNUSED, 32'sh7FFFFFFF, 6'd21);
      send_request(dq_pkg::OP_POP_BACK, 32'sd0, 6'd0);
      send_request(dq_pkg::OP_POP_FRONT, 32'sd0, 6'd0);
      wait_all_done();
   endtask

   // receiver held off at the start, then the store is filled and pushed past capacity
   task automatic test_full_store();
      logic signed [dq_pkg::WORD_W-1:0] last_word;
      last_word = '0;
      hold_request = 1'b1;
      while (shadow_count < CAPACITY) begin
         last_word = $urandom;
         send_request($urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                      last_word, 6'd0);
      end
      send_request(dq_pkg::OP_PUSH_BACK, 32'sd9, 6'd0);
      send_request(dq_pkg::OP_PUSH_FRONT, 32'sd9, 6'd0);
      send_request(dq_pkg::OP_INSERT, 32'sd9, 6'd0);
      send_request(dq_pkg::OP_INSERT, 32'sd9, 6'd63);
      send_request(dq_pkg::OP_READ, 32'sd0, 6'd63);
      send_request(dq_pkg::OP_FIND, last_word, 6'd0);
      while (shadow_count > 0)
         send_request($urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT,
                      32'sd0, 6'd0);
      send_request(dq_pkg::OP_POP_FRONT, 32'sd0, 6'd0);
      wait_all_done();
   endtask

   task automatic test_random_mix(input int idle_pct, input int stall_pct);
      logic [dq_pkg::OP_W-1:0] op;
      logic signed [dq_pkg::WORD_W-1:0] word;
      logic [dq_pkg::IDX_W-1:0] index;
      logic growing;
      int n;
      int roll;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      growing = 1'($urandom_range(1));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         n = shadow_count;
         if (n >= CAPACITY) growing = 1'b0;
         else if (n == 0) growing = 1'b1;
         else if ($urandom_range(149) == 0) growing = ~growing;

         roll = $urandom_range(99);
         if (n > 0 && roll < 30) word = shadow_words[$urandom_range(n - 1)];
         else if (roll < 55) begin
            case ($urandom_range(5))
               0: word = 32'sh7FFFFFFF;
               1: word = 32'sh80000000;
               2: word = -32'sd1;
               default: word = $urandom_range(7);
            endcase
         end else word = $urandom;

         if (n > 0 && $urandom_range(99) < 80)
            index = dq_pkg::IDX_W'($urandom_range(n - 1));
         else index = dq_pkg::IDX_W'($urandom_range(63));

         roll = $urandom_range(99);
         if (roll < 3) op = OP_UNUSED;
         else if (roll < (growing ? 38 : 13))
            op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
         else if (roll < (growing ? 55 : 20)) op = dq_pkg::OP_INSERT;
         else if (roll < (growing ? 65 : 70))
            op = $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
         else if (roll < 83) op = dq_pkg::OP_READ;
         else op = dq_pkg::OP_FIND;

         send_request(op, word, index);
      end
      wait_all_done();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_store();
      test_ends_and_middle();
      test_full_store();
      test_random_mix(0, 0);
      test_random_mix(49, 0);
      test_random_mix(0, 49);
      test_random_mix(23, 23);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_all_done();
      repeat (10) @(negedge clock);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/dq_pkg.sv
sv/dq_cell.sv
sv/dq_pick.sv
sv/bounded_deque_with_insert_find.sv
test/bounded_deque_with_insert_find_tb.sv
